// ===== hw/rtl/lock_wait_deadlock_detector_defines.svh =====
// Assertion macros for the deadlock detector.
`ifndef LOCK_WAIT_DEADLOCK_DETECTOR_DEFINES_SVH
`define LOCK_WAIT_DEADLOCK_DETECTOR_DEFINES_SVH
`ifndef SYNTH
`define LWDD_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define LWDD_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define LWDD_ASSERT(lbl, clk, rstn, expr)
`define LWDD_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

// ===== hw/rtl/lwdd_pkg.sv =====
`default_nettype none
package lwdd_pkg;

    localparam int KEY_W = 32;
    localparam int TID_W = 16;
    localparam int CLS_W = 2;

    localparam logic [1:0] REL_NONE = 2'd0;
    localparam logic [1:0] REL_HOLD = 2'd1;
    localparam logic [1:0] REL_WAIT = 2'd2;

    typedef enum logic [2:0] {
        RC_GRANTED  = 3'd0,
        RC_HELD     = 3'd1,
        RC_WAIT     = 3'd2,
        RC_DEADLOCK = 3'd3,
        RC_RELEASED = 3'd4,
        RC_FULL     = 3'd5,
        RC_UNKNOWN  = 3'd6
    } t_rc;

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LCHK, S_TRD, S_TCHK, S_DECIDE, S_RW, S_ARD, S_AQ,
        S_HRD, S_HCAP, S_WALK, S_WRD, S_WCHK, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_LRD, DP_NEXT, DP_LHIT, DP_TRD, DP_THIT, DP_SCAN0,
        DP_ALLOC, DP_RDL, DP_WHOLD, DP_WWAIT, DP_WNONE, DP_RDH, DP_CAPH,
        DP_STEP, DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   setc;
        t_rc    code;
    } t_cmd;

    typedef struct packed {
        logic op_rel;
        logic scan_eq_lcnt;
        logic scan_eq_tcnt;
        logic lmatch;
        logic tmatch;
        logic lfound;
        logic tfound;
        logic lfull;
        logic tfull;
        logic hfound;
        logic h_is_t;
        logic wmatch;
        logic step_end;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/lock_wait_deadlock_detector.sv =====
// Each item scans the used lock slots for its key, then the used thread slots for
// its thread; an acquire that must wait then walks up to THREAD_SLOTS chain steps,
// each a scan of the used lock slots. One item at a time: a new item is taken only
// after the result of the last one has been emitted. Reset clears slot counts and
// output valid; no clearing pass is run.
`default_nettype none
module lock_wait_deadlock_detector import lwdd_pkg::*; #(
    parameter int LOCK_SLOTS   = 32,
    parameter int THREAD_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,   // lock_key[31:0], thread_id[47:32]
    input  wire  [2:0]  i_s_axis_tuser,   // op[0], lock_class[2:1]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // result_code[2:0], holder_thread[18:3],
                                          // holder_valid[19], zero[23:20]
);

    t_cmd             w_cmd;
    t_status          w_st;
    logic [2:0]       w_code;
    logic [TID_W-1:0] w_hthr;
    logic             w_hval;

    lwdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_st       (w_st),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    lwdd_dp #(
        .LOCK_SLOTS   (LOCK_SLOTS),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (i_s_axis_tuser[0]),
        .i_kind      (i_s_axis_tuser[2:1]),
        .i_key       (i_s_axis_tdata[31:0]),
        .i_tid       (i_s_axis_tdata[47:32]),
        .i_out_ready (i_m_axis_tready),
        .o_st        (w_st),
        .o_out_valid (o_m_axis_tvalid),
        .o_code      (w_code),
        .o_hthr      (w_hthr),
        .o_hval      (w_hval)
    );

    assign o_m_axis_tdata = {4'b0000, w_hval, w_hthr, w_code};

endmodule
`default_nettype wire

// ===== hw/rtl/lwdd_ctrl.sv =====
`default_nettype none
module lwdd_ctrl import lwdd_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  t_status i_st,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = DP_NOP;
        o_cmd.setc  = 1'b0;
        o_cmd.code  = RC_GRANTED;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_LRD;
                end
            end
            S_LRD: begin
                if (i_st.scan_eq_lcnt) begin
                    o_cmd.op = DP_SCAN0;
                    n_state  = S_TRD;
                end else begin
                    o_cmd.op = DP_LRD;
                    n_state  = S_LCHK;
                end
            end
            S_LCHK: begin
                if (i_st.lmatch) begin
                    o_cmd.op = DP_LHIT;
                    n_state  = S_TRD;
                end else begin
                    o_cmd.op = DP_NEXT;
                    n_state  = S_LRD;
                end
            end
            S_TRD: begin
                if (i_st.scan_eq_tcnt) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = DP_TRD;
                    n_state  = S_TCHK;
                end
            end
            S_TCHK: begin
                if (i_st.tmatch) begin
                    o_cmd.op = DP_THIT;
                    n_state  = S_DECIDE;
                end else begin
                    o_cmd.op = DP_NEXT;
                    n_state  = S_TRD;
                end
            end
            S_DECIDE: begin
                o_cmd.setc = 1'b1;
                n_state    = S_DONE;
                if (i_st.op_rel) begin
                    if (!i_st.lfound) begin
                        o_cmd.code = RC_UNKNOWN;
                    end else if (!i_st.tfound) begin
                        o_cmd.code = RC_RELEASED;
                    end else begin
                        o_cmd.setc = 1'b0;
                        o_cmd.op   = DP_RDL;
                        n_state    = S_RW;
                    end
                end else if ((!i_st.lfound && i_st.lfull) ||
                             (!i_st.tfound && i_st.tfull)) begin
                    o_cmd.code = RC_FULL;
                end else begin
                    o_cmd.op = DP_ALLOC;
                    if (i_st.lfound) begin
                        o_cmd.setc = 1'b0;
                        n_state    = S_ARD;
                    end
                end
            end
            S_RW: begin
                o_cmd.op   = DP_WNONE;
                o_cmd.setc = 1'b1;
                o_cmd.code = RC_RELEASED;
                n_state    = S_DONE;
            end
            S_ARD: begin
                o_cmd.op = DP_RDL;
                n_state  = S_AQ;
            end
            S_AQ: begin
                o_cmd.setc = 1'b1;
                n_state    = S_DONE;
                if (!i_st.hfound) begin
                    o_cmd.op = DP_WHOLD;
                end else if (i_st.h_is_t) begin
                    o_cmd.code = RC_HELD;
                end else begin
                    o_cmd.op   = DP_WWAIT;
                    o_cmd.code = RC_WAIT;
                    n_state    = S_HRD;
                end
            end
            S_HRD: begin
                o_cmd.op = DP_RDH;
                n_state  = S_HCAP;
            end
            S_HCAP: begin
                o_cmd.op = DP_CAPH;
                n_state  = S_WALK;
            end
            S_WALK: begin
                if (i_st.step_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_SCAN0;
                    n_state  = S_WRD;
                end
            end
            S_WRD: begin
                if (i_st.scan_eq_lcnt) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_LRD;
                    n_state  = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_st.wmatch) begin
                    if (!i_st.hfound) begin
                        n_state = S_DONE;
                    end else if (i_st.h_is_t) begin
                        o_cmd.setc = 1'b1;
                        o_cmd.code = RC_DEADLOCK;
                        n_state    = S_DONE;
                    end else begin
                        o_cmd.op = DP_STEP;
                        n_state  = S_WALK;
                    end
                end else begin
                    o_cmd.op = DP_NEXT;
                    n_state  = S_WRD;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lwdd_dp.sv =====
`default_nettype none
`include "lock_wait_deadlock_detector_defines.svh"
module lwdd_dp import lwdd_pkg::*; #(
    parameter int LOCK_SLOTS   = 32,
    parameter int THREAD_SLOTS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    input  wire               i_op,
    input  wire [CLS_W-1:0]   i_kind,
    input  wire [KEY_W-1:0]   i_key,
    input  wire [TID_W-1:0]   i_tid,
    input  wire               i_out_ready,
    output t_status           o_st,
    output logic              o_out_valid,
    output logic [2:0]        o_code,
    output logic [TID_W-1:0]  o_hthr,
    output logic              o_hval
);

    localparam int LW   = $clog2(LOCK_SLOTS);
    localparam int LCW  = $clog2(LOCK_SLOTS + 1);
    localparam int TW   = $clog2(THREAD_SLOTS);
    localparam int TCW  = $clog2(THREAD_SLOTS + 1);
    localparam int SW   = (LCW > TCW) ? LCW : TCW;
    localparam int STW  = $clog2(THREAD_SLOTS + 1);
    localparam int RW   = 2 * THREAD_SLOTS;
    localparam int LMW  = CLS_W + KEY_W + RW;

    logic [LMW-1:0]   r_lmem [LOCK_SLOTS];
    logic [TID_W-1:0] r_tmem [THREAD_SLOTS];

    logic             r_op;
    logic [CLS_W-1:0] r_kind;
    logic [KEY_W-1:0] r_key;
    logic [TID_W-1:0] r_tid;
    logic [SW-1:0]    r_scan;
    logic [LCW-1:0]   r_lcnt;
    logic [TCW-1:0]   r_tcnt;
    logic [LW-1:0]    r_lidx;
    logic [TW-1:0]    r_tidx;
    logic             r_lfound;
    logic             r_tfound;
    logic [TW-1:0]    r_cur;
    logic [STW-1:0]   r_step;
    logic [LMW-1:0]   r_word;
    logic [TID_W-1:0] r_tword;
    t_rc              r_code;
    logic [TID_W-1:0] r_hthr;
    logic             r_hval;
    logic             r_ovalid;
    logic [2:0]       r_ocode;
    logic [TID_W-1:0] r_ohthr;
    logic             r_ohval;

    logic [RW-1:0]    w_row;
    logic [KEY_W-1:0] w_key;
    logic [CLS_W-1:0] w_kind;
    logic             w_hfound;
    logic [TW-1:0]    w_hidx;
    logic [TW-1:0]    w_teff;
    logic [RW-1:0]    w_nrow;
    logic [1:0]       w_nrel;
    logic             lm_we;
    logic [LW-1:0]    lm_wa;
    logic [LMW-1:0]   lm_wd;
    logic             lm_re;
    logic [LW-1:0]    lm_ra;
    logic             tm_re;
    logic [TW-1:0]    tm_ra;

    assign w_row  = r_word[RW-1:0];
    assign w_key  = r_word[RW +: KEY_W];
    assign w_kind = r_word[RW+KEY_W +: CLS_W];
    assign w_teff = r_tfound ? r_tidx : TW'(r_tcnt);

    always_comb begin
        w_hfound = 1'b0;
        w_hidx   = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
            if (w_row[2*i +: 2] == REL_HOLD) begin
                w_hfound = 1'b1;
                w_hidx   = TW'(i);
            end
        end
    end

    always_comb begin
        case (i_cmd.op)
            DP_WHOLD: w_nrel = REL_HOLD;
            DP_WWAIT: w_nrel = REL_WAIT;
            default:  w_nrel = REL_NONE;
        endcase
        w_nrow = w_row;
        w_nrow[{r_tidx, 1'b0} +: 2] = w_nrel;
    end

    always_comb begin
        lm_we = 1'b0;
        lm_wa = r_lidx;
        lm_wd = {r_kind, r_key, w_nrow};
        lm_re = 1'b0;
        lm_ra = LW'(r_scan);
        tm_re = 1'b0;
        tm_ra = TW'(r_scan);
        case (i_cmd.op)
            DP_LRD: lm_re = 1'b1;
            DP_RDL: begin
                lm_re = 1'b1;
                lm_ra = r_lidx;
            end
            DP_TRD: tm_re = 1'b1;
            DP_RDH: begin
                tm_re = 1'b1;
                tm_ra = r_cur;
            end
            DP_ALLOC: begin
                lm_we = !r_lfound;
                lm_wa = LW'(r_lcnt);
                lm_wd = '0;
                lm_wd[RW +: KEY_W]         = r_key;
                lm_wd[RW+KEY_W +: CLS_W]   = r_kind;
                lm_wd[{w_teff, 1'b0} +: 2] = REL_HOLD;
            end
            DP_WHOLD, DP_WWAIT, DP_WNONE: lm_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_lmem[lm_wa] <= lm_wd;
        end
        if (lm_re) begin
            r_word <= r_lmem[lm_ra];
        end
        if (i_cmd.op == DP_ALLOC && !r_tfound) begin
            r_tmem[TW'(r_tcnt)] <= r_tid;
        end
        if (tm_re) begin
            r_tword <= r_tmem[tm_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt   <= '0;
            r_tcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_ALLOC) begin
                if (!r_lfound) begin
                    r_lcnt <= r_lcnt + 1'b1;
                end
                if (!r_tfound) begin
                    r_tcnt <= r_tcnt + 1'b1;
                end
            end
            if (i_cmd.op == DP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setc) begin
            r_code <= i_cmd.code;
        end
        case (i_cmd.op)
            DP_LOAD: begin
                r_op     <= i_op;
                r_kind   <= i_kind;
                r_key    <= i_key;
                r_tid    <= i_tid;
                r_scan   <= '0;
                r_lfound <= 1'b0;
                r_tfound <= 1'b0;
                r_hthr   <= '0;
                r_hval   <= 1'b0;
            end
            DP_NEXT:  r_scan <= r_scan + 1'b1;
            DP_SCAN0: r_scan <= '0;
            DP_LHIT: begin
                r_lidx   <= LW'(r_scan);
                r_lfound <= 1'b1;
                r_scan   <= '0;
            end
            DP_THIT: begin
                r_tidx   <= TW'(r_scan);
                r_tfound <= 1'b1;
            end
            DP_ALLOC: begin
                r_tidx <= w_teff;
                if (!r_lfound) begin
                    r_lidx <= LW'(r_lcnt);
                end
            end
            DP_WWAIT: begin
                r_cur  <= w_hidx;
                r_step <= '0;
            end
            DP_CAPH: begin
                r_hthr <= r_tword;
                r_hval <= 1'b1;
            end
            DP_STEP: begin
                r_cur  <= w_hidx;
                r_step <= r_step + 1'b1;
            end
            DP_EMIT: begin
                r_ocode <= r_code;
                r_ohthr <= r_hthr;
                r_ohval <= r_hval;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_st.op_rel       = r_op;
        o_st.scan_eq_lcnt = (r_scan == SW'(r_lcnt));
        o_st.scan_eq_tcnt = (r_scan == SW'(r_tcnt));
        o_st.lmatch       = (w_kind == r_kind) && (w_key == r_key);
        o_st.tmatch       = (r_tword == r_tid);
        o_st.lfound       = r_lfound;
        o_st.tfound       = r_tfound;
        o_st.lfull        = (r_lcnt == LCW'(LOCK_SLOTS));
        o_st.tfull        = (r_tcnt == TCW'(THREAD_SLOTS));
        o_st.hfound       = w_hfound;
        o_st.h_is_t       = (w_hidx == r_tidx);
        o_st.wmatch       = (w_kind == r_kind) &&
                            (w_row[{r_cur, 1'b0} +: 2] == REL_WAIT);
        o_st.step_end     = (r_step == STW'(THREAD_SLOTS));
        o_st.out_free     = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_code      = r_ocode;
    assign o_hthr      = r_ohthr;
    assign o_hval      = r_ohval;

    `LWDD_ASSERT(a_lcnt_bound, i_clk, i_rst_n, r_lcnt <= LCW'(LOCK_SLOTS))
    `LWDD_ASSERT(a_tcnt_bound, i_clk, i_rst_n, r_tcnt <= TCW'(THREAD_SLOTS))
    `LWDD_ASSERT(a_emit_free, i_clk, i_rst_n, (i_cmd.op != DP_EMIT) || !r_ovalid || i_out_ready)
    `LWDD_ASSERT_NEXT(a_alloc_grows, i_clk, i_rst_n, (i_cmd.op == DP_ALLOC) && !r_lfound, r_lcnt == $past(r_lcnt) + 1'b1)

endmodule
`default_nettype wire
